// File: src/lhsm_pkg.sv
package lhsm_pkg;

   // op codes carried in req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // check kinds reported in rsp_tuser
   localparam logic [1:0] CHK_NONE   = 2'd0;
   localparam logic [1:0] CHK_SCAN   = 2'd1;
   localparam logic [1:0] CHK_WINDOW = 2'd2;

   localparam logic [15:0] RANGE_CAP_MM = 16'd6000;
   localparam logic [15:0] HALF_TURN    = 16'h8000;

   typedef struct packed {
      logic [15:0] speed_threshold;
      logic [15:0] near_distance;
      logic [15:0] flee_distance;
      logic [15:0] collision_angle;
      logic [15:0] window_angle;
   } cfg_type;

   typedef struct packed {
      logic               op;
      logic [8:0]         sample_index;
      logic [15:0]        range_mm;
      logic [15:0]        speed;
      logic signed [15:0] motion_angle;
      logic signed [15:0] target_angle;
   } req_item_type;

   typedef struct packed {
      logic       safe;
      logic [1:0] check_done;
   } rsp_item_type;

endpackage

// File: src/lhsm_scan_mem.sv
module lhsm_scan_mem #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lhsm_ctrl.sv
module lhsm_ctrl #(
   parameter int SCAN_POINTS = 512,
   parameter int IW          = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lhsm_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lhsm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lhsm_pkg::rsp_item_type rsp_item,
   output logic                  mem_wr_en,
   output logic [IW-1:0]         mem_wr_addr,
   output logic [15:0]           mem_wr_data,
   output logic                  mem_rd_en,
   output logic [IW-1:0]         mem_rd_addr,
   input  logic [15:0]           mem_rd_data
);

   import lhsm_pkg::*;

   localparam int CW = IW + 1;
   localparam int PW = 16 + CW;
   localparam int XW = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0] N_C      = CW'(SCAN_POINTS);
   localparam logic [IW-1:0] LAST_POS = IW'(SCAN_POINTS - 1);
   localparam logic [XW-1:0] N_X      = XW'(SCAN_POINTS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_WSETUP = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  speed_ff, speed_in;
   logic [15:0]  motion_ff, motion_in;
   logic [15:0]  target_ff, target_in;
   logic [1:0]   check_ff, check_in;
   logic         safe_flag_ff, safe_flag_in;
   logic [IW-1:0] centre_ff, centre_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic         dv_ff, dv_in;
   logic [15:0]  min_ff, min_in;
   logic         fail_ff, fail_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [XW-1:0] idx_ext;
   logic          idx_ok;
   logic [15:0]   diff;
   logic [15:0]   gap;
   logic          colliding;
   logic [PW-1:0] centre_prod;
   logic [PW-1:0] count_prod;
   logic [CW-1:0] start_raw;
   logic [CW-1:0] start_pos;
   logic [CW-1:0] start_next;
   logic [IW-1:0] first_pos;
   logic [IW-1:0] pos_next;
   logic          res_safe;

   // write address range check
   assign idx_ext = XW'(req_item.sample_index);
   assign idx_ok  = idx_ext < N_X;

   // wrapped angle gap, 0..half turn
   assign diff      = 16'(motion_ff - target_ff);
   assign gap       = (diff > HALF_TURN) ? 16'(~diff + 16'd1) : diff;
   assign colliding = {gap, 1'b0} < {1'b0, cfg.collision_angle};

   // window centre and length in sample positions
   assign centre_prod = PW'({~motion_ff[15], motion_ff[14:0]}) * PW'(N_C);
   assign count_prod  = PW'(cfg.window_angle) * PW'(N_C);

   // first sample after window start, wrapped
   assign start_raw  = {1'b0, centre_ff} - {1'b0, count_ff[CW-1:1]};
   assign start_pos  = start_raw[CW-1] ? CW'(start_raw + N_C) : start_raw;
   assign start_next = start_pos + CW'(1);
   assign first_pos  = (start_next == N_C) ? '0 : start_next[IW-1:0];

   assign pos_next = (pos_ff == LAST_POS) ? '0 : pos_ff + IW'(1);

   always_comb begin
      unique case (check_ff)
         CHK_SCAN:   res_safe = min_ff > cfg.flee_distance;
         CHK_WINDOW: res_safe = !fail_ff;
         default:    res_safe = safe_flag_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      speed_in     = speed_ff;
      motion_in    = motion_ff;
      target_in    = target_ff;
      check_in     = check_ff;
      safe_flag_in = safe_flag_ff;
      centre_in    = centre_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      dv_in        = dv_ff;
      min_in       = min_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.op == OP_WRITE) begin
                  mem_wr_en = idx_ok;
               end else begin
                  speed_in  = req_item.speed;
                  motion_in = req_item.motion_angle;
                  target_in = req_item.target_angle;
                  state_in  = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            centre_in = centre_prod[16+IW-1:16];
            count_in  = count_prod[PW-1:16];
            min_in    = RANGE_CAP_MM;
            fail_in   = 1'b0;
            dv_in     = 1'b0;
            priority if (speed_ff <= cfg.speed_threshold) begin
               check_in = CHK_NONE;
               state_in = ST_DONE;
            end else if (!safe_flag_ff) begin
               check_in = CHK_SCAN;
               pos_in   = '0;
               cnt_in   = N_C;
               state_in = ST_WALK;
            end else if (colliding) begin
               check_in = CHK_WINDOW;
               state_in = ST_WSETUP;
            end else begin
               check_in = CHK_NONE;
               state_in = ST_DONE;
            end
         end
         ST_WSETUP: begin
            pos_in   = first_pos;
            cnt_in   = count_ff;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            // one read issued per cycle while samples remain, data compared in the next cycle
            if (cnt_ff != '0) begin
               mem_rd_en = 1'b1;
               pos_in    = pos_next;
               cnt_in    = cnt_ff - CW'(1);
            end
            dv_in = (cnt_ff != '0);
            if (dv_ff) begin
               if (mem_rd_data < min_ff) begin
                  min_in = mem_rd_data;
               end
               if (mem_rd_data < cfg.near_distance) begin
                  fail_in = 1'b1;
               end
            end
            if (cnt_ff == '0 && !dv_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_item_in.safe       = res_safe;
               rsp_item_in.check_done = check_ff;
               safe_flag_in           = res_safe;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         check_ff     <= CHK_NONE;
         safe_flag_ff <= 1'b1;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         check_ff     <= check_in;
         safe_flag_ff <= safe_flag_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      speed_ff    <= speed_in;
      motion_ff   <= motion_in;
      target_ff   <= target_in;
      centre_ff   <= centre_in;
      count_ff    <= count_in;
      pos_ff      <= pos_in;
      min_ff      <= min_in;
      fail_ff     <= fail_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;
   assign mem_wr_addr = idx_ext[IW-1:0];
   assign mem_wr_data = req_item.range_mm;
   assign mem_rd_addr = pos_ff;

endmodule

// File: src/lidar_heading_safety_monitor.sv
// write items: accepted one per cycle while idle, the sample lands in the scan store at the accept edge
// evaluate items: after accept the sequencer runs DECIDE, then WSETUP and WALK for a heading
// window check or WALK alone for a full scan check, then DONE, which loads the result register
// throughput set by the single read port of the scan store: one sample compared per cycle
// input stays stalled while an evaluation runs; writes still flow while a result waits
// reset: control and config registers to their defaults, safe flag set, scan store keeps its contents
module lidar_heading_safety_monitor #(
   parameter int SCAN_POINTS = 512
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] sample_index, [24:9] range_mm, [40:25] speed, [56:41] motion_angle,
   // [72:57] target_angle, [79:73] zero
   input  logic [79:0] req_tdata,
   // [0] op
   input  logic        req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] safe, [7:1] zero
   output logic [7:0]  rsp_tdata,
   // [1:0] check_done
   output logic [1:0]  rsp_tuser,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import lhsm_pkg::*;

   localparam int IW = $clog2(SCAN_POINTS);

   // register map, one word each
   localparam logic [2:0] REG_SPEED_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_NEAR_DISTANCE   = 3'd1;
   localparam logic [2:0] REG_FLEE_DISTANCE   = 3'd2;
   localparam logic [2:0] REG_COLLISION_ANGLE = 3'd3;
   localparam logic [2:0] REG_WINDOW_ANGLE    = 3'd4;

   cfg_type       cfg_ff, cfg_in;
   logic          csr_write;
   logic [2:0]    csr_index;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   logic [15:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   logic [15:0]   mem_rd_data;

   // register writes complete in the access phase, no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SPEED_THRESHOLD: cfg_in.speed_threshold = csr_pwdata[15:0];
            REG_NEAR_DISTANCE:   cfg_in.near_distance   = csr_pwdata[15:0];
            REG_FLEE_DISTANCE:   cfg_in.flee_distance   = csr_pwdata[15:0];
            REG_COLLISION_ANGLE: cfg_in.collision_angle = csr_pwdata[15:0];
            REG_WINDOW_ANGLE:    cfg_in.window_angle    = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_threshold <= 16'd100;
         cfg_ff.near_distance   <= 16'd1000;
         cfg_ff.flee_distance   <= 16'd700;
         cfg_ff.collision_angle <= 16'd16384;
         cfg_ff.window_angle    <= 16'd16384;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux, unmapped addresses read zero
   always_comb begin
      unique case (csr_index)
         REG_SPEED_THRESHOLD: csr_prdata = {16'd0, cfg_ff.speed_threshold};
         REG_NEAR_DISTANCE:   csr_prdata = {16'd0, cfg_ff.near_distance};
         REG_FLEE_DISTANCE:   csr_prdata = {16'd0, cfg_ff.flee_distance};
         REG_COLLISION_ANGLE: csr_prdata = {16'd0, cfg_ff.collision_angle};
         REG_WINDOW_ANGLE:    csr_prdata = {16'd0, cfg_ff.window_angle};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // unpack the input item
   assign req_item.op           = req_tuser;
   assign req_item.sample_index = req_tdata[8:0];
   assign req_item.range_mm     = req_tdata[24:9];
   assign req_item.speed        = req_tdata[40:25];
   assign req_item.motion_angle = req_tdata[56:41];
   assign req_item.target_angle = req_tdata[72:57];

   // sequencer: accepts items, walks the store, holds the result register
   lhsm_ctrl #(
      .SCAN_POINTS (SCAN_POINTS),
      .IW          (IW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_item    (rsp_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // scan store, one write and one registered read per cycle
   lhsm_scan_mem #(
      .DEPTH  (SCAN_POINTS),
      .ADDR_W (IW)
   ) u_scan_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // pack the result item
   assign rsp_tdata = {7'd0, rsp_item.safe};
   assign rsp_tuser = rsp_item.check_done;

endmodule

// File: verif/lidar_heading_safety_monitor_tb.sv
module lidar_heading_safety_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lhsm_pkg::*;

   localparam int STORE_DEPTH = 512;
   // an evaluation walks at most the whole store, plus its setup and pipeline states
   localparam int SETTLE_CYCLES = STORE_DEPTH + 64;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 150, 40, 90, 170, 170};

   typedef enum int {
      REG_SPEED_THRESHOLD = 0,
      REG_NEAR_DISTANCE   = 1,
      REG_FLEE_DISTANCE   = 2,
      REG_COLLISION_ANGLE = 3,
      REG_WINDOW_ANGLE    = 4
   } csr_index_type;

   // safety predictor plus the queue of verdicts still owed by the block
   class safety_scoreboard;
      cfg_type      regs;
      logic [15:0]  scan_mm [STORE_DEPTH];
      logic         safe_now;
      rsp_item_type owed_verdicts [$];
      int           mismatches;

      function new();
         regs.speed_threshold = 16'd100;
         regs.near_distance   = 16'd1000;
         regs.flee_distance   = 16'd700;
         regs.collision_angle = 16'd16384;
         regs.window_angle    = 16'd16384;
         foreach (scan_mm[i]) scan_mm[i] = '0;
         safe_now   = 1'b1;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            REG_SPEED_THRESHOLD: regs.speed_threshold = value;
            REG_NEAR_DISTANCE:   regs.near_distance   = value;
            REG_FLEE_DISTANCE:   regs.flee_distance   = value;
            REG_COLLISION_ANGLE: regs.collision_angle = value;
            REG_WINDOW_ANGLE:    regs.window_angle    = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_verdicts.size();
      endfunction

      // shortest turn between two binary angles, 0..32768
      function int bearing_gap(logic [15:0] a, logic [15:0] b);
         logic [15:0] d;
         d = a - b;
         return (d > 16'h8000) ? (65536 - int'(d)) : int'(d);
      endfunction

      // capped minimum over the whole store must clear the flee distance
      function logic full_scan_clear();
         int m;
         m = int'(RANGE_CAP_MM);
         foreach (scan_mm[i]) if (int'(scan_mm[i]) < m) m = int'(scan_mm[i]);
         return m > int'(regs.flee_distance);
      endfunction

      // window of samples centred on the motion direction, start excluded
      function logic heading_window_clear(logic [15:0] motion);
         int centre;
         int count;
         int start;
         int pos;
         centre = int'((motion ^ HALF_TURN) >> 7);
         count  = int'(regs.window_angle >> 7);
         start  = centre - count / 2;
         if (start < 0) start += STORE_DEPTH;
         for (int k = 0; k < count; k++) begin
            pos = (start + 1 + k) % STORE_DEPTH;
            if (scan_mm[pos] < regs.near_distance) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(req_item_type it);
         rsp_item_type v;
         if (it.op == OP_WRITE) begin
            if (int'(it.sample_index) < STORE_DEPTH) scan_mm[it.sample_index] = it.range_mm;
            return;
         end
         v.check_done = CHK_NONE;
         if (it.speed > regs.speed_threshold) begin
            if (!safe_now) begin
               safe_now = full_scan_clear();
               v.check_done = CHK_SCAN;
            end else if (2 * bearing_gap(it.motion_angle, it.target_angle)
                         < int'(regs.collision_angle)) begin
               safe_now = heading_window_clear(it.motion_angle);
               v.check_done = CHK_WINDOW;
            end
         end
         v.safe = safe_now;
         owed_verdicts.push_back(v);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (owed_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with none owed: safe %0b check %0d",
                        $time, got.safe, got.check_done);
            return;
         end
         want = owed_verdicts.pop_front();
         if (got.safe !== want.safe || got.check_done !== want.check_done) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result mismatch: safe %0b/%0b check %0d/%0d (wanted/got)",
                        $time, want.safe, got.safe, want.check_done, got.check_done);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   safety_scoreboard sb = new();

   int   sender_idle_pct = 38;
   int   receiver_idle_pct = 68;
   logic rsp_hold = 1'b0;
   int   cycle_count = 0;
   int   last_index = 0;

   lidar_heading_safety_monitor #(.SCAN_POINTS(STORE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side backpressure, plus the long hold-off window
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= receiver_idle_pct);
   end

   // every accepted result goes straight to the scoreboard
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.safe       = rsp_tdata[0];
         got.check_done = rsp_tuser;
         sb.check_response(got);
      end
   end

   // write item with random filler in the evaluate fields
   function automatic req_item_type make_write(int idx, int range_mm);
      req_item_type it;
      it.op           = OP_WRITE;
      it.sample_index = idx[8:0];
      it.range_mm     = range_mm[15:0];
      it.speed        = 16'($urandom);
      it.motion_angle = 16'($urandom);
      it.target_angle = 16'($urandom);
      return it;
   endfunction

   // evaluate item with random filler in the write fields
   function automatic req_item_type make_eval(int speed, int motion, int target);
      req_item_type it;
      it.op           = OP_EVAL;
      it.sample_index = 9'($urandom);
      it.range_mm     = 16'($urandom);
      it.speed        = speed[15:0];
      it.motion_angle = motion[15:0];
      it.target_angle = target[15:0];
      return it;
   endfunction

   // offer one item, with random idle cycles ahead of it, and wait for accept
   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      // [8:0] index, [24:9] range, [40:25] speed, [56:41] motion, [72:57] target
      req_tdata  <= {7'd0, it.target_angle, it.motion_angle, it.speed,
                     it.range_mm, it.sample_index};
      req_tuser  <= it.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      if (it.op == OP_WRITE) last_index = int'(it.sample_index);
   endtask

   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      // setup phase, then access phase until pready, then back to idle
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(int'(idx) * 4);
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // stop offering and let every owed result come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // one above the larger of near and flee distance: neither near nor at flee distance
   function automatic int clear_floor();
      int lo;
      lo = int'(sb.regs.near_distance);
      if (int'(sb.regs.flee_distance) > lo) lo = int'(sb.regs.flee_distance);
      return lo + 1;
   endfunction

   function automatic int pick_clear_range();
      if (clear_floor() > 65535) return 65535;
      return int'($urandom_range(clear_floor(), 65535));
   endfunction

   // mostly clear ranges, some obstacles, some boundary values
   function automatic int pick_range();
      int p;
      int near_mm;
      int flee_mm;
      int edges [9];
      p = $urandom_range(99);
      near_mm = int'(sb.regs.near_distance);
      flee_mm = int'(sb.regs.flee_distance);
      edges = '{0, 65535, near_mm - 1, near_mm, flee_mm, flee_mm + 1, 5999, 6000, 6001};
      if (p < 10) return edges[$urandom_range(8)] & 16'hFFFF;
      if (p < 24) return int'($urandom_range(0, (near_mm + 200 > 65535) ? 65535 : near_mm + 200));
      return pick_clear_range();
   endfunction

   function automatic int pick_speed();
      int p;
      int thr;
      int edges [4];
      p   = $urandom_range(99);
      thr = int'(sb.regs.speed_threshold);
      edges = '{0, thr, (thr + 1) & 16'hFFFF, 65535};
      if (p < 15) return edges[$urandom_range(3)];
      if (p < 30) return int'($urandom_range(0, thr));
      if (thr >= 65535) return 65535;
      return int'($urandom_range(thr + 1, 65535));
   endfunction

   task automatic send_random_eval();
      int motion;
      int target;
      int half_cone;
      int off;
      // aim the heading window at the latest written sample some of the time
      if ($urandom_range(99) < 30)
         motion = ((last_index << 7) | int'($urandom_range(127))) ^ int'(HALF_TURN);
      else
         motion = int'($urandom_range(0, 65535));
      half_cone = int'(sb.regs.collision_angle) / 2;
      if ($urandom_range(99) < 60) begin
         off = int'($urandom_range(0, half_cone + 2));
         target = ($urandom_range(1) != 0) ? motion - off : motion + off;
      end else begin
         target = int'($urandom_range(0, 65535));
      end
      send_item(make_eval(pick_speed(), motion, target));
   endtask

   // mix of write bursts, obstacle clearing sweeps and evaluations
   task automatic random_traffic(int budget);
      int sent;
      int p;
      int burst;
      int lo;
      logic paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < budget) begin
         if (!paused && sent >= budget / 2) begin
            // sender pause until the block has answered everything
            paused = 1'b1;
            drain_results();
         end
         p = $urandom_range(99);
         if (p < 40) begin
            burst = $urandom_range(1, 6);
            for (int i = 0; i < burst; i++) begin
               send_item(make_write($urandom_range(0, STORE_DEPTH - 1), pick_range()));
               sent++;
            end
         end else if (p < 48) begin
            // clear obstacles so the unsafe state can be left again
            lo = clear_floor();
            burst = 0;
            if (lo <= 65535) begin
               for (int i = 0; i < STORE_DEPTH && burst < 40; i++) begin
                  if (int'(sb.scan_mm[i]) < lo) begin
                     send_item(make_write(i, $urandom_range(lo, 65535)));
                     burst++;
                     sent++;
                  end
               end
            end
         end else begin
            send_random_eval();
            sent++;
         end
      end
   endtask

   task automatic apply_phase_config(int ph);
      case (ph)
         1: begin
            // widest cone and window, every nonzero speed evaluated
            csr_write(REG_SPEED_THRESHOLD, 16'd0);
            csr_write(REG_NEAR_DISTANCE,   16'd1500);
            csr_write(REG_FLEE_DISTANCE,   16'd1200);
            csr_write(REG_COLLISION_ANGLE, 16'hFFFF);
            csr_write(REG_WINDOW_ANGLE,    16'hFFFF);
         end
         2: begin
            // nothing can trigger a check
            csr_write(REG_SPEED_THRESHOLD, 16'hFFFF);
            csr_write(REG_NEAR_DISTANCE,   16'hFFFF);
            csr_write(REG_FLEE_DISTANCE,   16'hFFFF);
            csr_write(REG_COLLISION_ANGLE, 16'd0);
            csr_write(REG_WINDOW_ANGLE,    16'd0);
         end
         3: begin
            // window shorter than one sample, counts as clear
            csr_write(REG_SPEED_THRESHOLD, 16'd300);
            csr_write(REG_NEAR_DISTANCE,   16'd900);
            csr_write(REG_FLEE_DISTANCE,   16'd500);
            csr_write(REG_COLLISION_ANGLE, 16'd20000);
            csr_write(REG_WINDOW_ANGLE,    16'd100);
         end
         default: begin
            csr_write(REG_SPEED_THRESHOLD, 16'($urandom_range(0, 2000)));
            csr_write(REG_NEAR_DISTANCE,   16'($urandom_range(300, 3000)));
            csr_write(REG_FLEE_DISTANCE,   16'($urandom_range(100, 2500)));
            csr_write(REG_COLLISION_ANGLE, 16'($urandom));
            csr_write(REG_WINDOW_ANGLE,    16'($urandom_range(0, 24000)));
         end
      endcase
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every store entry gets written before anything reads it
      send_item(make_write(0, 65535));
      for (int i = 1; i < STORE_DEPTH; i++) send_item(make_write(i, $urandom_range(6001, 65535)));

      // directed: default window for motion 0 covers entries 193..320
      send_item(make_eval(0, 0, 0));                 // low speed
      send_item(make_eval(100, 0, 0));               // speed equal to threshold
      send_item(make_eval(65535, 0, 0));             // window check, all clear
      send_item(make_eval(101, -32768, 32767));      // window wraps around entry 0
      send_item(make_eval(5000, 0, -32768));         // opposite direction, not colliding
      send_item(make_eval(5000, 8192, 0));           // cone edge, just outside
      send_item(make_eval(5000, 8191, 0));           // cone edge, just inside
      send_item(make_eval(5000, 32767, -32768));     // gap across the half turn
      send_item(make_write(192, 0));                 // window start is not read
      send_item(make_eval(5000, 0, 0));
      send_item(make_write(256, 1000));              // equal to near distance is clear
      send_item(make_eval(5000, 0, 0));
      send_item(make_write(320, 999));               // last window entry, below near
      send_item(make_eval(5000, 0, 0));              // goes unsafe
      send_item(make_eval(50, 0, 0));                // unsafe, low speed
      send_item(make_write(192, 700));               // minimum equal to flee distance
      send_item(make_eval(5000, 0, 0));              // full scan keeps it unsafe
      send_item(make_write(192, 701));
      send_item(make_eval(5000, 0, 0));              // full scan recovers
      send_item(make_write(192, 65535));
      send_item(make_write(320, 65535));
      send_item(make_eval(65535, 12345, 12345));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clock);
            apply_phase_config(ph);
         end
         if (ph < 2) begin
            sender_idle_pct   = 38;
            receiver_idle_pct = 68;
         end else if (ph < 4) begin
            sender_idle_pct   = 68;
            receiver_idle_pct = 38;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (ph == 3) begin
            // receiver stops for a long stretch while items keep coming
            fork
               begin
                  repeat (40) @(posedge clock);
                  rsp_hold <= 1'b1;
                  repeat (2000) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         random_traffic(PHASE_ITEMS[ph]);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: lidar_heading_safety_monitor.f
src/lhsm_pkg.sv
src/lhsm_scan_mem.sv
src/lhsm_ctrl.sv
src/lidar_heading_safety_monitor.sv
verif/lidar_heading_safety_monitor_tb.sv
